// ----- rtl/core/imt_pkg.sv -----
`timescale 1ns / 1ps

package imt_pkg;

  localparam int ACTION_BITS = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  localparam logic [ACTION_BITS-1:0] ACT_ASSIGN  = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_RESTART = 2'd2;

  localparam logic [STATUS_BITS-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_IDLE,
    ST_SCAN,
    ST_INS_B,
    ST_INS_E,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ----- rtl/core/imt_in_if.sv -----
`timescale 1ns / 1ps

interface imt_in_if
  import imt_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 8
);
  logic                         valid;
  logic                         ready;
  logic [ACTION_BITS-1:0]       action;
  logic signed [KEY_BITS-1:0]   key_begin;
  logic signed [KEY_BITS-1:0]   key_end;
  logic [VALUE_BITS-1:0]        new_value;

  modport source (output valid, action, key_begin, key_end, new_value, input ready);
  modport sink (input valid, action, key_begin, key_end, new_value, output ready);
endinterface

// ----- rtl/core/imt_out_if.sv -----
`timescale 1ns / 1ps

interface imt_out_if
  import imt_pkg::*;
#(
  parameter int VALUE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  lookup_value;
  logic [STATUS_BITS-1:0] status;
  logic [COUNT_BITS-1:0]  entry_count;

  modport source (output valid, lookup_value, status, entry_count, input ready);
  modport sink (input valid, lookup_value, status, entry_count, output ready);
endinterface

// ----- rtl/core/imt_cfg_if.sv -----
`timescale 1ns / 1ps

interface imt_cfg_if #(
  parameter int VALUE_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] wdata;

  modport source (output valid, wdata, input ready);
  modport sink (input valid, wdata, output ready);
endinterface

// ----- rtl/core/imt_table_mem.sv -----
`timescale 1ns / 1ps

module imt_table_mem
  import imt_pkg::*;
#(
  parameter int ADDR_BITS  = 5,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 8
) (
  input  logic                  clk,
  input  mem_ctl_t              ctl,
  input  logic [ADDR_BITS-1:0]  waddr,
  input  logic [KEY_BITS-1:0]   wkey,
  input  logic [VALUE_BITS-1:0] wval,
  input  logic [ADDR_BITS-1:0]  raddr,
  output logic [KEY_BITS-1:0]   rkey,
  output logic [VALUE_BITS-1:0] rval
);

  logic [KEY_BITS-1:0]   key_mem [2**ADDR_BITS];
  logic [VALUE_BITS-1:0] val_mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[waddr] <= wkey;
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rkey <= key_mem[raddr];
      rval <= val_mem[raddr];
    end
  end

endmodule

// ----- rtl/core/imt_scan.sv -----
`timescale 1ns / 1ps

module imt_scan
  import imt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [ACTION_BITS-1:0]               act,
  input  logic [KEY_BITS-1:0]                  kb,
  input  logic [KEY_BITS-1:0]                  ke,
  input  logic [VALUE_BITS-1:0]                nv,
  input  logic [VALUE_BITS-1:0]                dflt,
  input  logic                                 out_free,
  output logic                                 ready,
  output logic                                 done,
  output logic [VALUE_BITS-1:0]                res_value,
  output logic [STATUS_BITS-1:0]               res_status,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     res_count
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int PTR_W  = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 3);
  localparam int ADDR_W = IDX_W + 1;

  state_t state_r, state_nxt;

  logic                   cur_r, cur_nxt;
  logic [PTR_W-1:0]       used_r, used_nxt;
  logic                   pend_r, pend_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic                   dv_r, dv_nxt;
  logic [CNT_W-1:0]       wcnt_r, wcnt_nxt;
  logic [VALUE_BITS-1:0]  lastv_r, lastv_nxt;
  logic [VALUE_BITS-1:0]  endv_r, endv_nxt;
  logic [VALUE_BITS-1:0]  lv_r, lv_nxt;
  logic                   ins_done_r, ins_done_nxt;
  logic                   build_r, build_nxt;
  logic                   empty_r, empty_nxt;
  logic [ACTION_BITS-1:0] act_r, act_nxt;
  logic [KEY_BITS-1:0]    kb_r, kb_nxt;
  logic [KEY_BITS-1:0]    ke_r, ke_nxt;
  logic [VALUE_BITS-1:0]  nv_r, nv_nxt;

  mem_ctl_t              mctl;
  logic [ADDR_W-1:0]     waddr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wval;
  logic [ADDR_W-1:0]     raddr;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;

  logic                  hold_ins;
  logic                  scan_end;
  logic                  build_ok;
  logic                  push_en;
  logic [KEY_BITS-1:0]   push_key;
  logic [VALUE_BITS-1:0] push_val;

  imt_table_mem #(
    .ADDR_BITS  (ADDR_W),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk   (clk),
    .ctl   (mctl),
    .waddr (waddr),
    .wkey  (wkey),
    .wval  (wval),
    .raddr (raddr),
    .rkey  (rkey),
    .rval  (rval)
  );

  assign hold_ins = dv_r && build_r && !ins_done_r && (rkey > ke_r);
  assign scan_end = !dv_r && (rd_ptr_r == used_r);
  assign build_ok = build_r && (wcnt_r <= CNT_W'(TABLE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        state_nxt = pend_r ? ST_FIN : ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = (act == ACT_RESTART) ? ST_LOAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hold_ins) begin
          state_nxt = ST_INS_B;
        end else if (scan_end) begin
          state_nxt = (build_r && !ins_done_r) ? ST_INS_B : ST_FIN;
        end
      end
      ST_INS_B: begin
        state_nxt = ST_INS_E;
      end
      ST_INS_E: begin
        state_nxt = ST_SCAN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cur_nxt      = cur_r;
    used_nxt     = used_r;
    pend_nxt     = pend_r;
    rd_ptr_nxt   = rd_ptr_r;
    dv_nxt       = dv_r;
    wcnt_nxt     = wcnt_r;
    lastv_nxt    = lastv_r;
    endv_nxt     = endv_r;
    lv_nxt       = lv_r;
    ins_done_nxt = ins_done_r;
    build_nxt    = build_r;
    empty_nxt    = empty_r;
    act_nxt      = act_r;
    kb_nxt       = kb_r;
    ke_nxt       = ke_r;
    nv_nxt       = nv_r;
    mctl         = '0;
    waddr        = {~cur_r, wcnt_r[IDX_W-1:0]};
    wkey         = '0;
    wval         = '0;
    raddr        = {cur_r, rd_ptr_r[IDX_W-1:0]};
    push_en      = 1'b0;
    push_key     = rkey;
    push_val     = rval;
    ready        = 1'b0;
    done         = 1'b0;
    res_value    = lv_r;
    res_status   = STAT_DONE;
    res_count    = used_r;

    case (state_r)
      ST_LOAD: begin
        mctl.wr_en = 1'b1;
        waddr      = {cur_r, IDX_W'(0)};
        wkey       = '0;
        wval       = dflt;
        used_nxt   = PTR_W'(1);
      end
      ST_IDLE: begin
        ready = 1'b1;
        if (start) begin
          act_nxt      = act;
          kb_nxt       = kb;
          ke_nxt       = ke;
          nv_nxt       = nv;
          pend_nxt     = 1'b1;
          rd_ptr_nxt   = '0;
          dv_nxt       = 1'b0;
          wcnt_nxt     = '0;
          ins_done_nxt = 1'b0;
          build_nxt    = (act == ACT_ASSIGN) && (kb < ke);
          empty_nxt    = (act == ACT_ASSIGN) && (kb >= ke);
        end
      end
      ST_SCAN: begin
        if (!hold_ins) begin
          if (dv_r) begin
            if (rkey <= kb_r) begin
              lv_nxt = rval;
            end
            if (build_r) begin
              if (rkey <= ke_r) begin
                endv_nxt = rval;
              end
              push_en = (rkey < kb_r) || (rkey > ke_r);
            end
          end
          if (rd_ptr_r < used_r) begin
            mctl.rd_en = 1'b1;
            rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
            dv_nxt     = 1'b1;
          end else begin
            dv_nxt = 1'b0;
          end
        end
      end
      ST_INS_B: begin
        push_en  = 1'b1;
        push_key = kb_r;
        push_val = nv_r;
      end
      ST_INS_E: begin
        push_en      = 1'b1;
        push_key     = ke_r;
        push_val     = endv_r;
        ins_done_nxt = 1'b1;
      end
      ST_FIN: begin
        if (act_r == ACT_RESTART) begin
          res_value = dflt;
        end else if (build_ok) begin
          res_value  = nv_r;
          res_count  = PTR_W'(wcnt_r);
        end else if (build_r) begin
          res_status = STAT_FULL;
        end else if (empty_r) begin
          res_status = STAT_EMPTY;
        end
        if (out_free) begin
          done     = 1'b1;
          pend_nxt = 1'b0;
          if (build_ok) begin
            cur_nxt  = ~cur_r;
            used_nxt = PTR_W'(wcnt_r);
          end
        end
      end
      default: begin
        ready = 1'b0;
      end
    endcase

    // Equal neighbors collapse into the earlier breakpoint.
    if (push_en && ((wcnt_r == '0) || (push_val != lastv_r))) begin
      mctl.wr_en = (wcnt_r < CNT_W'(TABLE_DEPTH));
      wkey       = push_key;
      wval       = push_val;
      wcnt_nxt   = wcnt_r + CNT_W'(1);
      lastv_nxt  = push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cur_r   <= 1'b0;
      used_r  <= PTR_W'(1);
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    dv_r       <= dv_nxt;
    wcnt_r     <= wcnt_nxt;
    lastv_r    <= lastv_nxt;
    endv_r     <= endv_nxt;
    lv_r       <= lv_nxt;
    ins_done_r <= ins_done_nxt;
    build_r    <= build_nxt;
    empty_r    <= empty_nxt;
    act_r      <= act_nxt;
    kb_r       <= kb_nxt;
    ke_r       <= ke_nxt;
    nv_r       <= nv_nxt;
  end

endmodule

// ----- rtl/core/interval_map_table_core.sv -----
`timescale 1ns / 1ps
// Channel    Port       Direction  Transfer carries
// input      in_chan    sink       action, key_begin, key_end, new_value
// result     out_chan   source     lookup_value, status, entry_count
// config     cfg_chan   sink       default_value (wdata)
//
// The single read port of the table memory is walked one entry per cycle, except
// while the assign's two new breakpoints are written, and a non-empty assign
// writes the new table into the second bank as it goes. After reset, the
// ST_LOAD state loads entry zero before in_chan.ready rises. A stalled result
// sits in the output register while the next item is taken.

module interval_map_table_core
  import imt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  imt_in_if.sink    in_chan,
  imt_out_if.source out_chan,
  imt_cfg_if.sink   cfg_chan
);

  localparam int PTR_W = $clog2(TABLE_DEPTH + 1);

  logic [VALUE_BITS-1:0]  default_r;
  logic                   out_valid_r;
  logic [VALUE_BITS-1:0]  out_value_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [COUNT_BITS-1:0]  out_count_r;

  logic                   out_free;
  logic                   scan_ready;
  logic                   done;
  logic [VALUE_BITS-1:0]  res_value;
  logic [STATUS_BITS-1:0] res_status;
  logic [PTR_W-1:0]       res_count;
  logic [KEY_BITS-1:0]    kb_biased;
  logic [KEY_BITS-1:0]    ke_biased;

  // Inverting the sign bit makes signed key order match unsigned order.
  assign kb_biased = {~in_chan.key_begin[KEY_BITS-1], in_chan.key_begin[KEY_BITS-2:0]};
  assign ke_biased = {~in_chan.key_end[KEY_BITS-1], in_chan.key_end[KEY_BITS-2:0]};

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = scan_ready;
  assign cfg_chan.ready = 1'b1;

  imt_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_chan.valid && scan_ready),
    .act        (in_chan.action),
    .kb         (kb_biased),
    .ke         (ke_biased),
    .nv         (in_chan.new_value),
    .dflt       (default_r),
    .out_free   (out_free),
    .ready      (scan_ready),
    .done       (done),
    .res_value  (res_value),
    .res_status (res_status),
    .res_count  (res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_r <= '0;
    end else if (cfg_chan.valid) begin
      default_r <= cfg_chan.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
      out_count_r  <= COUNT_BITS'(res_count);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.lookup_value = out_value_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.entry_count  = out_count_r;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import imt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 32;
  localparam int VALUE_BITS  = 8;

  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;

  localparam logic signed [KEY_BITS-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_BITS-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [VALUE_BITS-1:0]  value;
    logic [STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]  count;
  } answer_t;

  logic clk;
  logic rst_n;

  imt_in_if  #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) in_chan ();
  imt_out_if #(.VALUE_BITS(VALUE_BITS)) out_chan ();
  imt_cfg_if #(.VALUE_BITS(VALUE_BITS)) cfg_chan ();

  interval_map_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  logic [KEY_BITS-1:0]   map_keys [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] map_vals [TABLE_DEPTH];
  int                    map_count;
  logic [VALUE_BITS-1:0] dflt_value;

  answer_t pending_answers[$];
  int      mismatches;
  logic    quiet;
  logic    long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [VALUE_BITS-1:0] value_at_key(logic [KEY_BITS-1:0] bkey);
    logic [VALUE_BITS-1:0] v;
    logic                  past;
    v = map_vals[0];
    past = 1'b0;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      if (!past && i < map_count) begin
        if (map_keys[i] <= bkey) v = map_vals[i];
        else past = 1'b1;
      end
    end
    return v;
  endfunction

  function automatic void reload_map();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      map_keys[i] = '0;
      map_vals[i] = '0;
    end
    map_vals[0] = dflt_value;
    map_count = 1;
  endfunction

  function automatic logic [STATUS_BITS-1:0] assign_range(logic [KEY_BITS-1:0] b,
                                                           logic [KEY_BITS-1:0] e,
                                                           logic [VALUE_BITS-1:0] v);
    logic [KEY_BITS-1:0]   tk [TABLE_DEPTH+2];
    logic [VALUE_BITS-1:0] tv [TABLE_DEPTH+2];
    logic [VALUE_BITS-1:0] end_val;
    int                    n;
    int                    m;
    end_val = value_at_key(e);
    n = 0;
    for (int i = 0; i < map_count; i++) begin
      if (map_keys[i] < b) begin
        tk[n] = map_keys[i];
        tv[n] = map_vals[i];
        n++;
      end
    end
    tk[n] = b;
    tv[n] = v;
    n++;
    tk[n] = e;
    tv[n] = end_val;
    n++;
    for (int i = 0; i < map_count; i++) begin
      if (map_keys[i] > e && n < TABLE_DEPTH + 2) begin
        tk[n] = map_keys[i];
        tv[n] = map_vals[i];
        n++;
      end
    end
    m = 1;
    for (int i = 1; i < n; i++) begin
      if (tv[i] != tv[m-1]) begin
        tk[m] = tk[i];
        tv[m] = tv[i];
        m++;
      end
    end
    if (m > TABLE_DEPTH) return STAT_FULL;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      map_keys[i] = (i < m) ? tk[i] : '0;
      map_vals[i] = (i < m) ? tv[i] : '0;
    end
    map_count = m;
    return STAT_DONE;
  endfunction

  function automatic answer_t predict_answer(logic [ACTION_BITS-1:0] act,
                                             logic [KEY_BITS-1:0] kb,
                                             logic [KEY_BITS-1:0] ke,
                                             logic [VALUE_BITS-1:0] nv);
    answer_t             ans;
    logic [KEY_BITS-1:0] b;
    logic [KEY_BITS-1:0] e;
    b = {~kb[KEY_BITS-1], kb[KEY_BITS-2:0]};
    e = {~ke[KEY_BITS-1], ke[KEY_BITS-2:0]};
    ans.status = STAT_DONE;
    if (act == ACT_ASSIGN) begin
      if (b >= e) ans.status = STAT_EMPTY;
      else ans.status = assign_range(b, e, nv);
    end else if (act == ACT_RESTART) begin
      reload_map();
    end
    ans.value = value_at_key(b);
    ans.count = map_count[COUNT_BITS-1:0];
    return ans;
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      k = int'($urandom_range(0, 40)) - 20;
      return k;
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_MIN + 1;
        default: return KEY_MAX - 1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    if ($urandom_range(0, 1) == 0) return VALUE_BITS'($urandom_range(0, 3));
    return VALUE_BITS'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [ACTION_BITS-1:0] act,
                           input logic [KEY_BITS-1:0] kb,
                           input logic [KEY_BITS-1:0] ke,
                           input logic [VALUE_BITS-1:0] nv);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid     = 1'b1;
    in_chan.action    = act;
    in_chan.key_begin = kb;
    in_chan.key_end   = ke;
    in_chan.new_value = nv;
    do @(posedge clk); while (!in_chan.ready);
    pending_answers.push_back(predict_answer(act, kb, ke, nv));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_default(input logic [VALUE_BITS-1:0] val);
    drain_results();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.wdata = val;
    do @(posedge clk); while (!cfg_chan.ready);
    dflt_value = val;
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic random_items(input int count);
    int                          sel;
    logic signed [KEY_BITS-1:0] ka;
    logic signed [KEY_BITS-1:0] kz;
    logic signed [KEY_BITS-1:0] tmp;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      ka = pick_key();
      kz = pick_key();
      if (sel < 60) begin
        if ($urandom_range(0, 9) != 0 && ka > kz) begin
          tmp = ka;
          ka = kz;
          kz = tmp;
        end
        send_item(ACT_ASSIGN, ka, kz, pick_value());
      end else if (sel < 92) begin
        send_item(ACT_LOOKUP, ka, kz, VALUE_BITS'($urandom_range(0, 255)));
      end else if (sel < 96) begin
        send_item(ACT_RESTART, ka, kz, VALUE_BITS'($urandom_range(0, 255)));
      end else begin
        send_item(ACT_UNUSED, ka, kz, VALUE_BITS'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_edges();
    send_item(ACT_LOOKUP, KEY_MIN, KEY_MAX, 8'h00);
    send_item(ACT_LOOKUP, KEY_MAX, KEY_MIN, 8'hFF);
    send_item(ACT_ASSIGN, KEY_MIN, KEY_MAX, 8'hFF);
    send_item(ACT_LOOKUP, KEY_MAX, 32'sd0, 8'h00);
    send_item(ACT_ASSIGN, 32'sd5, 32'sd5, 8'h11);
    send_item(ACT_ASSIGN, 32'sd10, -32'sd10, 8'h22);
    send_item(ACT_UNUSED, 32'sd7, 32'sd9, 8'h33);
    send_item(ACT_ASSIGN, -32'sd1, 32'sd0, 8'hAA);
    send_item(ACT_RESTART, -32'sd1, 32'sd0, 8'h00);
    send_item(ACT_ASSIGN, KEY_MIN, KEY_MAX, dflt_value);
  endtask

  task automatic test_table_full();
    send_item(ACT_RESTART, 32'sd0, 32'sd0, 8'h00);
    for (int k = 0; k < 8; k++) begin
      send_item(ACT_ASSIGN, 2 * k, 2 * k + 1, 8'(k + 1));
    end
    send_item(ACT_LOOKUP, 32'sd14, 32'sd0, 8'h00);
    send_item(ACT_ASSIGN, 32'sd0, 32'sd20, 8'h33);
  endtask

  task automatic test_output_stall();
    @(posedge clk);
    long_hold_req = 1'b1;
    random_items(40);
  endtask

  task automatic test_sender_pause();
    random_items(120);
    drain_results();
    random_items(130);
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        stall_left = 300;
        long_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_chan.ready = 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result: value %h status %h count %0d", $time,
                 out_chan.lookup_value, out_chan.status, out_chan.entry_count);
        mismatches++;
      end else begin
        want = pending_answers.pop_front();
        if (out_chan.lookup_value !== want.value) begin
          $display("%0t: lookup_value mismatch: expected %h, actual %h", $time,
                   want.value, out_chan.lookup_value);
          mismatches++;
        end
        if (out_chan.status !== want.status) begin
          $display("%0t: status mismatch: expected %h, actual %h", $time,
                   want.status, out_chan.status);
          mismatches++;
        end
        if (out_chan.entry_count !== want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d", $time,
                   want.count, out_chan.entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_LOOKUP;
    in_chan.key_begin = '0;
    in_chan.key_end = '0;
    in_chan.new_value = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.wdata = '0;
    dflt_value = '0;
    reload_map();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_default(8'hA5);
    test_edges();
    test_table_full();
    write_default(8'hFF);
    send_item(ACT_RESTART, 32'sd0, 32'sd0, 8'h00);
    random_items(200);
    write_default(8'h00);
    send_item(ACT_RESTART, 32'sd0, 32'sd0, 8'h00);
    test_output_stall();
    test_sender_pause();
    write_default(VALUE_BITS'($urandom_range(0, 255)));
    @(posedge clk);
    quiet = 1'b1;
    random_items(150);
    drain_results();
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- interval_map_table_core.f -----
rtl/core/imt_pkg.sv
rtl/core/imt_in_if.sv
rtl/core/imt_out_if.sv
rtl/core/imt_cfg_if.sv
rtl/core/imt_table_mem.sv
rtl/core/imt_scan.sv
rtl/core/interval_map_table_core.sv
dv/testbench.sv
